// ===== hw/rtl/tapd_pkg.sv =====
// Shared constants, register map and command rounding for the PD position controller.
`timescale 1ns / 1ps

package tapd_pkg;

	// Build default for the fixed height set point, Q4.12
	localparam logic signed [15:0] TARGET_HEIGHT_DEF = 16'sd4096;

	// Register map, byte address 4*index
	localparam int NUM_REGS  = 8;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_TARGET_X     = 3'd0;
	localparam reg_idx_t REG_TARGET_Z     = 3'd1;
	localparam reg_idx_t REG_PROP_GAIN_X  = 3'd2;
	localparam reg_idx_t REG_PROP_GAIN_Y  = 3'd3;
	localparam reg_idx_t REG_PROP_GAIN_Z  = 3'd4;
	localparam reg_idx_t REG_DERIV_GAIN_X = 3'd5;
	localparam reg_idx_t REG_DERIV_GAIN_Y = 3'd6;
	localparam reg_idx_t REG_DERIV_GAIN_Z = 3'd7;

	// Full scale of a Q1.14 command
	localparam logic [15:0] CMD_ONE = 16'd16384;

	// Width of the exact PD sum, Q16.20, which leaves headroom for negation
	localparam int SUM_W = 36;

	typedef logic signed [SUM_W-1:0] pd_sum_t;

	// Apply the axis sign, drop six bits rounding half away from zero,
	// then clamp the magnitude to one.
	function automatic logic [15:0] to_cmd(input pd_sum_t s, input logic negate);
		pd_sum_t           v;
		logic [SUM_W-1:0]  mag;
		logic [SUM_W-7:0]  rnd;
		logic [15:0]       sat;
		v   = negate ? -s : s;
		mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		rnd = (SUM_W-6)'((mag + SUM_W'(32)) >> 6);
		if (rnd > (SUM_W-6)'(CMD_ONE)) begin
			sat = CMD_ONE;
		end else begin
			sat = rnd[15:0];
		end
		return v[SUM_W-1] ? 16'(-sat) : sat;
	endfunction

endpackage

// ===== hw/rtl/three_axis_pd_position_controller_core.sv =====
// Top level of the three-axis PD position controller with clamped Q1.14 commands.
`timescale 1ns / 1ps

// Three-axis PD position controller. Each input item carries a measured
// position (pos_x, pos_y, pos_z, Q4.12) and a seen flag. For a seen item the
// block forms error = position - target per axis and the sum
// P*error + D*(previous error - error), with gains in Q8.8; the target for y
// is the build parameter TARGET_HEIGHT. roll_cmd is the negated x sum,
// pitch_cmd the z sum and climb_cmd the negated y sum, each rounded half away
// from zero to Q1.14 and clamped to plus or minus 1.0 (16384). The errors of
// the last seen item are kept for the next derivative term; an item that is
// not seen returns three zero commands and leaves them untouched.
// Throughput is one item per clock cycle while the output is not stalled.
// An item passes three registers in turn (input, product, result), and the
// result register holds its commands until they are taken. The stored
// errors are updated as a seen item leaves the input register, so the
// following item already sees them. A stalled output back-pressures each
// stage in turn through a combinational ready chain.
// Gains and targets sit on an APB port: register i at byte address 4*i, the
// low 16 bits of pwdata written, reads returning the sign-extended value.
// Write them only while no item is in flight.

module three_axis_pd_position_controller_core #(
	parameter logic signed [15:0] TARGET_HEIGHT = tapd_pkg::TARGET_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tapd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Input item channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          pos_x,
	input  logic signed [15:0]          pos_y,
	input  logic signed [15:0]          pos_z,
	input  logic                        seen,
	// Result item channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          roll_cmd,
	output logic signed [15:0]          pitch_cmd,
	output logic signed [15:0]          climb_cmd
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [15:0]  cfg_q [tapd_pkg::NUM_REGS];
	tapd_pkg::reg_idx_t  reg_idx;
	logic                cfg_wr;
	logic signed [15:0]  rd_val;

	assign reg_idx = paddr[tapd_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign rd_val  = cfg_q[reg_idx];
	assign prdata  = {{16{rd_val[15]}}, rd_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tapd_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			cfg_q[reg_idx] <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Handshake: each stage advances when the one after it has room
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, out_valid_q;
	logic ready_s2, ready_s3;

	assign ready_s3  = !out_valid_q || out_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign in_ready  = !valid_s1 || ready_s2;
	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic signed [15:0] pos_x_s1, pos_y_s1, pos_z_s1;
	logic               seen_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			pos_z_s1 <= pos_z;
			seen_s1  <= seen;
		end
	end

	// Errors, derivative differences and products
	logic signed [16:0] prev_err_x_q, prev_err_y_q, prev_err_z_q;
	logic signed [16:0] err_x, err_y, err_z;
	logic signed [17:0] diff_x, diff_y, diff_z;
	logic signed [32:0] pp_x, pp_y, pp_z;
	logic signed [33:0] dp_x, dp_y, dp_z;
	logic signed [15:0] tgt_x, tgt_z;
	logic               adv_s1;

	assign tgt_x = cfg_q[tapd_pkg::REG_TARGET_X];
	assign tgt_z = cfg_q[tapd_pkg::REG_TARGET_Z];

	assign err_x = {pos_x_s1[15], pos_x_s1} - {tgt_x[15], tgt_x};
	assign err_y = {pos_y_s1[15], pos_y_s1} - {TARGET_HEIGHT[15], TARGET_HEIGHT};
	assign err_z = {pos_z_s1[15], pos_z_s1} - {tgt_z[15], tgt_z};

	assign diff_x = {prev_err_x_q[16], prev_err_x_q} - {err_x[16], err_x};
	assign diff_y = {prev_err_y_q[16], prev_err_y_q} - {err_y[16], err_y};
	assign diff_z = {prev_err_z_q[16], prev_err_z_q} - {err_z[16], err_z};

	assign pp_x = 33'(cfg_q[tapd_pkg::REG_PROP_GAIN_X]) * 33'(err_x);
	assign pp_y = 33'(cfg_q[tapd_pkg::REG_PROP_GAIN_Y]) * 33'(err_y);
	assign pp_z = 33'(cfg_q[tapd_pkg::REG_PROP_GAIN_Z]) * 33'(err_z);

	assign dp_x = 34'(cfg_q[tapd_pkg::REG_DERIV_GAIN_X]) * 34'(diff_x);
	assign dp_y = 34'(cfg_q[tapd_pkg::REG_DERIV_GAIN_Y]) * 34'(diff_y);
	assign dp_z = 34'(cfg_q[tapd_pkg::REG_DERIV_GAIN_Z]) * 34'(diff_z);

	assign adv_s1 = valid_s1 && ready_s2;

	// Store the errors as a seen item leaves stage 1; hold them otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_x_q <= '0;
			prev_err_y_q <= '0;
			prev_err_z_q <= '0;
		end else if (adv_s1 && seen_s1) begin
			prev_err_x_q <= err_x;
			prev_err_y_q <= err_y;
			prev_err_z_q <= err_z;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: product register
	// ------------------------------------------------------------------
	logic signed [32:0] pp_x_s2, pp_y_s2, pp_z_s2;
	logic signed [33:0] dp_x_s2, dp_y_s2, dp_z_s2;
	logic               seen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pp_x_s2 <= pp_x;
			pp_y_s2 <= pp_y;
			pp_z_s2 <= pp_z;
			dp_x_s2 <= dp_x;
			dp_y_s2 <= dp_y;
			dp_z_s2 <= dp_z;
			seen_s2 <= seen_s1;
		end
	end

	// Sum, sign, round and clamp
	tapd_pkg::pd_sum_t sum_x, sum_y, sum_z;
	logic [15:0]       cmd_roll, cmd_pitch, cmd_climb;

	assign sum_x = {{3{pp_x_s2[32]}}, pp_x_s2} + {{2{dp_x_s2[33]}}, dp_x_s2};
	assign sum_y = {{3{pp_y_s2[32]}}, pp_y_s2} + {{2{dp_y_s2[33]}}, dp_y_s2};
	assign sum_z = {{3{pp_z_s2[32]}}, pp_z_s2} + {{2{dp_z_s2[33]}}, dp_z_s2};

	assign cmd_roll  = seen_s2 ? tapd_pkg::to_cmd(sum_x, 1'b1) : '0;
	assign cmd_pitch = seen_s2 ? tapd_pkg::to_cmd(sum_z, 1'b0) : '0;
	assign cmd_climb = seen_s2 ? tapd_pkg::to_cmd(sum_y, 1'b1) : '0;

	// ------------------------------------------------------------------
	// Stage 3: result register
	// ------------------------------------------------------------------
	logic signed [15:0] roll_q, pitch_q, climb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s3) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			roll_q  <= cmd_roll;
			pitch_q <= cmd_pitch;
			climb_q <= cmd_climb;
		end
	end

	assign roll_cmd  = roll_q;
	assign pitch_cmd = pitch_q;
	assign climb_cmd = climb_q;

endmodule

// ===== tb/three_axis_pd_position_controller_core_tb.sv =====
// Self-checking testbench for the three-axis PD position controller core.
`timescale 1ns / 1ps

module three_axis_pd_position_controller_core_tb;

	// Height set point that the block is built with (no override on the instance)
	localparam logic signed [15:0] HEIGHT_SET = tapd_pkg::TARGET_HEIGHT_DEF;
	localparam logic signed [15:0] Q14_ONE    = 16'sd16384;

	// One measured frame and the three commands it produces
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               seen;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] climb;
	} cmds_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          psel    = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite  = 1'b0;
	logic [tapd_pkg::ADDR_W-1:0]   paddr   = '0;
	logic [31:0]                   pwdata  = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	logic                in_valid = 1'b0;
	logic                in_ready;
	logic signed [15:0]  pos_x    = '0;
	logic signed [15:0]  pos_y    = '0;
	logic signed [15:0]  pos_z    = '0;
	logic                seen     = 1'b0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [15:0]  roll_cmd;
	logic signed [15:0]  pitch_cmd;
	logic signed [15:0]  climb_cmd;

	// Frames waiting to be sent, and commands owed by the block in order
	frame_t frames_to_send[$];
	cmds_t  cmds_due[$];

	// Shadow of the register file and of the stored errors
	logic signed [15:0] ctrl_regs [tapd_pkg::NUM_REGS] = '{default: '0};
	logic signed [16:0] err_x_last = '0;
	logic signed [16:0] err_y_last = '0;
	logic signed [16:0] err_z_last = '0;

	// Traffic shaping knobs, set per phase
	int send_gap_max = 0;
	int stall_pct    = 0;
	int burst_left   = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	logic in_taken   = 1'b0;
	frame_t next_frame;

	// Run statistics
	int mismatches    = 0;
	int frames_taken  = 0;
	int frames_lost   = 0;
	int cmds_checked  = 0;
	int cmds_clamped  = 0;
	int reg_writes    = 0;

	three_axis_pd_position_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.seen      (seen),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.roll_cmd  (roll_cmd),
		.pitch_cmd (pitch_cmd),
		.climb_cmd (climb_cmd)
	);

	always #5 clk = ~clk;

	// Give up after a fixed time; a correct run finishes far sooner
	initial begin
		#2_000_000;
		$display("Timed out with %0d commands still owed", cmds_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Drop six bits of a Q18.20 sum, rounding half away from zero, and clamp
	// the magnitude to one in Q1.14.
	function automatic logic signed [15:0] to_q14(input logic signed [37:0] v);
		logic [37:0] mag;
		logic [37:0] rnd;
		mag = v[37] ? 38'(-v) : 38'(v);
		rnd = (mag + 38'd32) >> 6;
		if (rnd > 38'd16384) begin
			rnd = 38'd16384;
		end
		return v[37] ? 16'(-rnd[15:0]) : rnd[15:0];
	endfunction

	// Work out the commands for one accepted frame and advance the stored errors.
	// A frame without the target gives zero commands and keeps the errors.
	function automatic cmds_t predict_commands(input frame_t f);
		logic signed [16:0] ex;
		logic signed [16:0] ey;
		logic signed [16:0] ez;
		logic signed [37:0] sx;
		logic signed [37:0] sy;
		logic signed [37:0] sz;
		cmds_t c;
		c = '0;
		if (f.seen) begin
			ex = f.x - ctrl_regs[tapd_pkg::REG_TARGET_X];
			ey = f.y - HEIGHT_SET;
			ez = f.z - ctrl_regs[tapd_pkg::REG_TARGET_Z];
			sx = ctrl_regs[tapd_pkg::REG_PROP_GAIN_X] * ex
				+ ctrl_regs[tapd_pkg::REG_DERIV_GAIN_X] * (err_x_last - ex);
			sy = ctrl_regs[tapd_pkg::REG_PROP_GAIN_Y] * ey
				+ ctrl_regs[tapd_pkg::REG_DERIV_GAIN_Y] * (err_y_last - ey);
			sz = ctrl_regs[tapd_pkg::REG_PROP_GAIN_Z] * ez
				+ ctrl_regs[tapd_pkg::REG_DERIV_GAIN_Z] * (err_z_last - ez);
			// Roll and climb act against the x and height errors
			c.roll  = to_q14(-sx);
			c.pitch = to_q14(sz);
			c.climb = to_q14(-sy);
			err_x_last = ex;
			err_y_last = ey;
			err_z_last = ez;
		end
		return c;
	endfunction

	function automatic void note_mismatch(input string what, input logic signed [31:0] want,
			input logic signed [31:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch on %s after %0d commands: expected %0d, got %0d",
				what, cmds_checked, want, got);
		end
	endfunction

	function automatic logic signed [15:0] rand_setting(input int span);
		int pick;
		int mag;
		pick = $urandom_range(15);
		if (pick == 0) begin
			return 16'sh7fff;
		end
		if (pick == 1) begin
			return 16'sh8000;
		end
		if (pick < 4) begin
			return 16'($urandom());
		end
		mag = $urandom_range(0, span);
		return $urandom_range(1) ? 16'(-mag) : 16'(mag);
	endfunction

	// Input side: hold each frame until taken, and send in bursts split by gaps
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (frames_to_send.size() != 0) begin
				next_frame = frames_to_send.pop_front();
				pos_x    <= next_frame.x;
				pos_y    <= next_frame.y;
				pos_z    <= next_frame.z;
				seen     <= next_frame.seen;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: stall in runs of random length
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check results first, so that a command can never be matched against the
	// frame accepted at the same edge; then predict for the newly taken frame.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cmds_due.size() == 0) begin
					note_mismatch("unexpected command", 0, 1);
				end else begin
					if (roll_cmd != cmds_due[0].roll) begin
						note_mismatch("roll_cmd", cmds_due[0].roll, roll_cmd);
					end
					if (pitch_cmd != cmds_due[0].pitch) begin
						note_mismatch("pitch_cmd", cmds_due[0].pitch, pitch_cmd);
					end
					if (climb_cmd != cmds_due[0].climb) begin
						note_mismatch("climb_cmd", cmds_due[0].climb, climb_cmd);
					end
					if (cmds_due[0].roll == Q14_ONE || cmds_due[0].roll == -Q14_ONE
							|| cmds_due[0].climb == Q14_ONE || cmds_due[0].climb == -Q14_ONE) begin
						cmds_clamped++;
					end
					void'(cmds_due.pop_front());
					cmds_checked++;
				end
			end
			if (in_valid && in_ready) begin
				cmds_due.push_back(predict_commands('{pos_x, pos_y, pos_z, seen}));
				frames_taken++;
				if (!seen) begin
					frames_lost++;
				end
			end
		end
	end

	task automatic send_frame(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z, input logic s);
		frames_to_send.push_back('{x, y, z, s});
	endtask

	// Wait until every frame is out and every owed command has arrived,
	// then let the pipeline settle before touching the registers.
	task automatic drain();
		while (frames_to_send.size() != 0 || in_valid || cmds_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	// Write one register, then read it back; upper write bits are junk on purpose
	task automatic write_reg(input tapd_pkg::reg_idx_t idx, input logic signed [15:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom()), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		ctrl_regs[idx] = val;
		reg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata != {{16{val[15]}}, val}) begin
			note_mismatch("register read-back", {{16{val[15]}}, val}, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input logic signed [15:0] tx, input logic signed [15:0] tz,
			input logic signed [15:0] kpx, input logic signed [15:0] kpy,
			input logic signed [15:0] kpz, input logic signed [15:0] kdx,
			input logic signed [15:0] kdy, input logic signed [15:0] kdz);
		write_reg(tapd_pkg::REG_TARGET_X, tx);
		write_reg(tapd_pkg::REG_TARGET_Z, tz);
		write_reg(tapd_pkg::REG_PROP_GAIN_X, kpx);
		write_reg(tapd_pkg::REG_PROP_GAIN_Y, kpy);
		write_reg(tapd_pkg::REG_PROP_GAIN_Z, kpz);
		write_reg(tapd_pkg::REG_DERIV_GAIN_X, kdx);
		write_reg(tapd_pkg::REG_DERIV_GAIN_Y, kdy);
		write_reg(tapd_pkg::REG_DERIV_GAIN_Z, kdz);
	endtask

	initial begin
		int ph;
		int n;
		int pick;
		int span;
		int offx;
		int offy;
		int offz;
		logic s;

		// Hold reset, then release it away from the rising edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_gap_max = 3;
		stall_pct    = 30;

		// Reset values: zero gains, so every command is zero, but the stored
		// errors still move on seen frames
		send_frame(16'sh7fff, 16'sh8000, 16'sd1234, 1'b1);
		send_frame(16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_frame(-16'sd1, 16'sd5, 16'sd7, 1'b1);
		drain();

		// Unit proportional gain: 32 error steps make half a command step, so
		// these frames land on and around the rounding ties
		apply_settings(16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
		send_frame(16'sd32, HEIGHT_SET + 16'sd32, 16'sd32, 1'b1);
		send_frame(-16'sd32, HEIGHT_SET - 16'sd32, -16'sd32, 1'b1);
		send_frame(16'sd31, HEIGHT_SET + 16'sd33, -16'sd31, 1'b1);
		send_frame(16'sd96, HEIGHT_SET - 16'sd96, -16'sd96, 1'b1);
		send_frame(16'sd500, 16'sd500, 16'sd500, 1'b0);
		send_frame(-16'sd33, HEIGHT_SET, 16'sd33, 1'b1);
		drain();

		// Extreme targets and gains drive every command of a seen frame into the clamp
		apply_settings(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000);
		send_frame(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
		send_frame(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
		send_frame(16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd0, 16'sd0, 16'sd0, 1'b1);
		send_frame(16'sh7fff, 16'sh8000, 16'sd0, 1'b1);
		drain();

		apply_settings(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_frame(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1);
		send_frame(16'sh7fff, 16'sh8000, 16'sh8000, 1'b1);
		send_frame(16'shffff, 16'shffff, 16'shffff, 1'b1);
		drain();

		// Derivative only: a frame without the target must not disturb the
		// error that the next seen frame is compared against
		apply_settings(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd64, 16'sd64, 16'sd64);
		send_frame(16'sd100, HEIGHT_SET + 16'sd100, 16'sd100, 1'b1);
		send_frame(16'sd300, HEIGHT_SET + 16'sd250, -16'sd200, 1'b1);
		send_frame(16'sd9000, 16'sd9000, 16'sd9000, 1'b0);
		send_frame(16'sd150, HEIGHT_SET, 16'sd0, 1'b1);
		drain();

		// Random phases: new settings each time, positions mostly a walk
		// around the set points with now and then a jump, a lost target, or
		// an arbitrary frame. Every fourth phase runs with no idling at all.
		for (ph = 0; ph < 8; ph++) begin
			span = 1 << $urandom_range(2, 10);
			apply_settings(rand_setting(8192), rand_setting(8192), rand_setting(span),
				rand_setting(span), rand_setting(span), rand_setting(span),
				rand_setting(span), rand_setting(span));
			send_gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 8);
			stall_pct    = (ph % 4 == 0) ? 0 : ((ph % 4 == 1) ? 0 : $urandom_range(10, 50));
			offx = int'($urandom_range(0, 2048)) - 1024;
			offy = int'($urandom_range(0, 2048)) - 1024;
			offz = int'($urandom_range(0, 2048)) - 1024;
			for (n = 0; n < 200; n++) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					send_frame(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
				end else begin
					if (pick < 14) begin
						offx = int'($urandom_range(0, 16384)) - 8192;
						offy = int'($urandom_range(0, 16384)) - 8192;
						offz = int'($urandom_range(0, 16384)) - 8192;
					end else begin
						span = 1 << $urandom_range(0, 10);
						offx += int'($urandom_range(0, 2 * span)) - span;
						offy += int'($urandom_range(0, 2 * span)) - span;
						offz += int'($urandom_range(0, 2 * span)) - span;
					end
					s = ($urandom_range(9) != 0);
					send_frame(16'(ctrl_regs[tapd_pkg::REG_TARGET_X] + offx),
						16'(HEIGHT_SET + offy),
						16'(ctrl_regs[tapd_pkg::REG_TARGET_Z] + offz), s);
				end
			end
			drain();
		end

		$display("Covered %0d frames (%0d without target) over %0d register writes;",
			frames_taken, frames_lost, reg_writes);
		$display("%0d commands checked, %0d with a clamped roll or climb, %0d mismatches.",
			cmds_checked, cmds_clamped, mismatches);
		if (mismatches == 0 && cmds_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
